// ----- hdl/pnz_pkg.sv -----
// ----------------------------------------------------------------------------
// pnz_pkg
// shared constants and types for the 2d gradient noise evaluator
// ----------------------------------------------------------------------------
package pnz_pkg;

    localparam int COORD_W = 32;
    localparam int ENTRY_W = 8;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    // advance strobes for the three fade pipeline registers
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_fade_en;

endpackage

// ----- hdl/pnz_if.sv -----
// ----------------------------------------------------------------------------
// pnz_if
// valid/ready channels for point items and noise results
// ----------------------------------------------------------------------------
interface pnz_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   mode;
    logic signed [pnz_pkg::COORD_W-1:0]     coord_x;
    logic signed [pnz_pkg::COORD_W-1:0]     coord_y;
    logic        [pnz_pkg::ENTRY_W-1:0]     entry_index;
    logic        [pnz_pkg::ENTRY_W-1:0]     entry_value;

    modport source (output valid, mode, coord_x, coord_y, entry_index, entry_value,
                    input ready);
    modport sink   (input valid, mode, coord_x, coord_y, entry_index, entry_value,
                    output ready);
endinterface

interface pnz_out_if #(parameter int NOISE_W = 19);
    logic                      valid;
    logic                      ready;
    logic signed [NOISE_W-1:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

// ----- hdl/perlin_noise_2d_eval.sv -----
// ----------------------------------------------------------------------------
// perlin_noise_2d_eval
// 2d gradient noise at a q16.16 point through an 8-register pipeline
// ----------------------------------------------------------------------------
// an accepted evaluate transaction is registered through stages 1 to 8 to its result
// throughput: one transaction per cycle while results are taken; a stage holds
// on stall and bubbles collapse, so input waits only when every stage is full
// load transactions write the table copies in order and produce no result
// reset clears the valid bits only; table contents are undefined until loaded
module perlin_noise_2d_eval #(
    parameter int TABLE_SIZE = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pnz_in_if.sink    i_pt,
    pnz_out_if.source o_res
);

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int SW = IW + pnz_pkg::ENTRY_W;
    localparam int WW = FRAC_BITS + 6;
    localparam int GW = FRAC_BITS + 4;
    localparam int MW = WW + GW;
    localparam int NW = FRAC_BITS + 3;
    localparam logic signed [GW-1:0] ONE = GW'(1) <<< FRAC_BITS;

    function automatic logic signed [GW-1:0] grad(input logic [2:0] h,
                                                  input logic signed [GW-1:0] dx,
                                                  input logic signed [GW-1:0] dy);
        logic signed [GW-1:0] u;
        logic signed [GW-1:0] v;
        logic signed [GW-1:0] gu;
        logic signed [GW-1:0] gv;
        u  = h[2] ? dy : dx;
        v  = h[2] ? dx : dy;
        gu = h[0] ? -u : u;
        gv = h[1] ? -(v <<< 1) : (v <<< 1);
        return gu + gv;
    endfunction

    logic [9:1] en;
    logic [8:1] r_v;

    // stage 1
    logic                        r1_mode;
    logic [IW-1:0]               r1_idx;
    logic [pnz_pkg::ENTRY_W-1:0] r1_val;
    logic [IW-1:0]               r1_cy;
    logic [FRAC_BITS-1:0]        r1_fx;
    logic [FRAC_BITS-1:0]        r1_fy;
    logic [pnz_pkg::ENTRY_W-1:0] w_pa;
    logic [pnz_pkg::ENTRY_W-1:0] w_pb;
    // stage 2
    logic [FRAC_BITS-1:0]        r2_fx;
    logic [FRAC_BITS-1:0]        r2_fy;
    logic [pnz_pkg::ENTRY_W-1:0] w_h00;
    logic [pnz_pkg::ENTRY_W-1:0] w_h01;
    logic [pnz_pkg::ENTRY_W-1:0] w_h10;
    logic [pnz_pkg::ENTRY_W-1:0] w_h11;
    // stage 3..8
    logic signed [GW-1:0] r3_g00, r3_g10, r3_g01, r3_g11;
    logic signed [GW-1:0] r4_g00, r4_g01, r4_d0, r4_d1;
    logic signed [MW-1:0] r5_m0, r5_m1;
    logic signed [GW-1:0] r5_g00, r5_g01;
    logic signed [WW-1:0] r5_wv, r6_wv;
    logic signed [GW-1:0] r6_row0, r6_dr, r7_row0;
    logic signed [MW-1:0] r7_mr;
    logic signed [NW-1:0] r8_res;
    logic signed [WW-1:0] w_wu, w_wv;

    logic [IW-1:0]        n_cx, n_ha, n_hb, n_ld_idx;
    logic signed [GW-1:0] n_dx, n_dy, n_dx1, n_dy1, n_row0, n_row1;
    logic signed [MW-1:0] n_m0, n_m1, n_mr;
    logic signed [GW-1:0] n_res;
    logic                 n_tbl_we;
    pnz_pkg::t_fade_en    fade_en;

    always_comb begin
        en[9] = o_res.ready;
        for (int k = 8; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
        fade_en.s2 = en[2];
        fade_en.s3 = en[3];
        fade_en.s4 = en[4];
    end

    assign i_pt.ready = en[1];

    always_comb begin
        n_cx     = IW'($unsigned(i_pt.coord_x) >> FRAC_BITS);
        n_ld_idx = IW'(i_pt.entry_index);
        n_ha     = IW'(SW'(w_pa) + SW'(r1_cy));
        n_hb     = IW'(SW'(w_pb) + SW'(r1_cy));
        n_tbl_we = en[2] && r_v[1] && (r1_mode == pnz_pkg::MODE_LOAD);
        n_dx     = GW'(r2_fx);
        n_dy     = GW'(r2_fy);
        n_dx1    = n_dx - ONE;
        n_dy1    = n_dy - ONE;
        n_m0     = MW'(w_wu) * MW'(r4_d0);
        n_m1     = MW'(w_wu) * MW'(r4_d1);
        n_row0   = r5_g00 + r5_m0[FRAC_BITS+GW-1:FRAC_BITS];
        n_row1   = r5_g01 + r5_m1[FRAC_BITS+GW-1:FRAC_BITS];
        n_mr     = MW'(r6_wv) * MW'(r6_dr);
        n_res    = r7_row0 + r7_mr[FRAC_BITS+GW-1:FRAC_BITS];
    end

    // first copy serves the corner lookups, the others the hash lookups
    pnz_ram #(.DEPTH(TABLE_SIZE), .AW(IW)) u_ram_c (
        .i_clk     (i_clk),
        .i_we      (i_pt.valid && en[1] && (i_pt.mode == pnz_pkg::MODE_LOAD)),
        .i_waddr   (n_ld_idx),
        .i_wdata   (i_pt.entry_value),
        .i_re      (en[1]),
        .i_raddr_a (n_cx),
        .i_raddr_b (n_cx + IW'(1)),
        .o_rdata_a (w_pa),
        .o_rdata_b (w_pb)
    );

    pnz_ram #(.DEPTH(TABLE_SIZE), .AW(IW)) u_ram_a (
        .i_clk     (i_clk),
        .i_we      (n_tbl_we),
        .i_waddr   (r1_idx),
        .i_wdata   (r1_val),
        .i_re      (en[2]),
        .i_raddr_a (n_ha),
        .i_raddr_b (n_ha + IW'(1)),
        .o_rdata_a (w_h00),
        .o_rdata_b (w_h01)
    );

    pnz_ram #(.DEPTH(TABLE_SIZE), .AW(IW)) u_ram_b (
        .i_clk     (i_clk),
        .i_we      (n_tbl_we),
        .i_waddr   (r1_idx),
        .i_wdata   (r1_val),
        .i_re      (en[2]),
        .i_raddr_a (n_hb),
        .i_raddr_b (n_hb + IW'(1)),
        .o_rdata_a (w_h10),
        .o_rdata_b (w_h11)
    );

    pnz_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
        .i_clk  (i_clk),
        .i_en   (fade_en),
        .i_t    (r1_fx),
        .o_fade (w_wu)
    );

    pnz_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
        .i_clk  (i_clk),
        .i_en   (fade_en),
        .i_t    (r1_fy),
        .o_fade (w_wv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= i_pt.valid;
            if (en[2]) r_v[2] <= r_v[1] && (r1_mode == pnz_pkg::MODE_EVAL);
            for (int k = 3; k <= 8; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_mode <= i_pt.mode;
            r1_idx  <= n_ld_idx;
            r1_val  <= i_pt.entry_value;
            r1_cy   <= IW'($unsigned(i_pt.coord_y) >> FRAC_BITS);
            r1_fx   <= i_pt.coord_x[FRAC_BITS-1:0];
            r1_fy   <= i_pt.coord_y[FRAC_BITS-1:0];
        end
        if (en[2]) begin
            r2_fx <= r1_fx;
            r2_fy <= r1_fy;
        end
        if (en[3]) begin
            r3_g00 <= grad(w_h00[2:0], n_dx,  n_dy);
            r3_g10 <= grad(w_h10[2:0], n_dx1, n_dy);
            r3_g01 <= grad(w_h01[2:0], n_dx,  n_dy1);
            r3_g11 <= grad(w_h11[2:0], n_dx1, n_dy1);
        end
        if (en[4]) begin
            r4_g00 <= r3_g00;
            r4_g01 <= r3_g01;
            r4_d0  <= r3_g10 - r3_g00;
            r4_d1  <= r3_g11 - r3_g01;
        end
        if (en[5]) begin
            r5_m0  <= n_m0;
            r5_m1  <= n_m1;
            r5_g00 <= r4_g00;
            r5_g01 <= r4_g01;
            r5_wv  <= w_wv;
        end
        if (en[6]) begin
            r6_row0 <= n_row0;
            r6_dr   <= n_row1 - n_row0;
            r6_wv   <= r5_wv;
        end
        if (en[7]) begin
            r7_mr   <= n_mr;
            r7_row0 <= r6_row0;
        end
        if (en[8]) begin
            r8_res <= n_res[NW-1:0];
        end
    end

    assign o_res.valid       = r_v[8];
    assign o_res.noise_value = r8_res;

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[1] && r1_mode == pnz_pkg::MODE_LOAD && en[2]) |=> !r_v[2])
        else $error("load transaction entered the noise pipeline");

    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt.ready |-> (!r_v[1] || en[2]))
        else $error("input ready while first stage cannot advance");

    a_tbl_write_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_tbl_we |=> !(r_v[2] && $past(r1_mode) == pnz_pkg::MODE_LOAD))
        else $error("hash table write overlapped a stage two item");

endmodule

// ----- hdl/pnz_ram.sv -----
// ----------------------------------------------------------------------------
// pnz_ram
// permutation table copy: one write port, two registered read ports
// ----------------------------------------------------------------------------
module pnz_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [pnz_pkg::ENTRY_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr_a,
    input  logic [AW-1:0]               i_raddr_b,
    output logic [pnz_pkg::ENTRY_W-1:0] o_rdata_a,
    output logic [pnz_pkg::ENTRY_W-1:0] o_rdata_b
);

    logic [pnz_pkg::ENTRY_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ----- hdl/pnz_fade.sv -----
// ----------------------------------------------------------------------------
// pnz_fade
// fade curve 6t^5-15t^4+10t^3 over three multiplier stages
// ----------------------------------------------------------------------------
module pnz_fade #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  pnz_pkg::t_fade_en        i_en,
    input  logic [FRAC_BITS-1:0]     i_t,
    output logic signed [FRAC_BITS+5:0] o_fade
);

    localparam int WW = FRAC_BITS + 6;
    localparam int PW = 2 * WW;
    localparam logic signed [WW-1:0] C15 = WW'(15) <<< FRAC_BITS;
    localparam logic signed [WW-1:0] C10 = WW'(10) <<< FRAC_BITS;

    logic signed [WW-1:0] n_t;
    logic signed [WW-1:0] n_s1;
    logic signed [PW-1:0] n_ps;
    logic signed [PW-1:0] n_pc;
    logic signed [PW-1:0] n_p3;
    logic signed [PW-1:0] n_pf;

    logic signed [WW-1:0] r_t2;
    logic signed [WW-1:0] r_s2;
    logic signed [WW-1:0] r_c2;
    logic signed [WW-1:0] r_c3;
    logic signed [WW-1:0] r_s3;
    logic signed [WW-1:0] r_fade;

    always_comb begin
        n_t  = WW'(i_t);
        n_s1 = (n_t <<< 2) + (n_t <<< 1) - C15;
        n_ps = PW'(n_t) * PW'(n_s1);
        n_pc = PW'(n_t) * PW'(n_t);
        n_p3 = PW'(r_c2) * PW'(r_t2);
        n_pf = PW'(r_c3) * PW'(r_s3);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_t2 <= n_t;
            r_s2 <= n_ps[FRAC_BITS+WW-1:FRAC_BITS];
            r_c2 <= n_pc[FRAC_BITS+WW-1:FRAC_BITS];
        end
        if (i_en.s3) begin
            r_c3 <= n_p3[FRAC_BITS+WW-1:FRAC_BITS];
            r_s3 <= r_s2 + C10;
        end
        if (i_en.s4) begin
            r_fade <= n_pf[FRAC_BITS+WW-1:FRAC_BITS];
        end
    end

    assign o_fade = r_fade;

endmodule
